// ===== rtl/eatbv_pkg.sv =====
// Package for the Euler angle to basis vector unit.
// Holds widths, CORDIC constants and arithmetic helpers; no dependencies.
package eatbv_pkg;

    localparam int OUT_WIDTH    = 16;
    localparam int ANG_WIDTH    = 16;
    localparam int CORDIC_STEPS = 24;
    localparam int Q_WIDTH      = 34;   // Q30 values plus guard bits
    localparam int Z_WIDTH      = 34;
    localparam int FULL_TURN    = 23040;
    localparam int QUARTER_TURN = 5760;
    localparam logic signed [Q_WIDTH-1:0] ONE_Q30   = 34'sd1073741824;
    localparam logic signed [Q_WIDTH-1:0] CORDIC_K  = 34'sd652032874;
    localparam logic [31:0] PI_Q30 = 32'd3373259426;

    typedef logic signed [Q_WIDTH-1:0] q30_t;
    typedef logic signed [OUT_WIDTH-1:0] out_t;

    typedef struct packed {
        q30_t x;
        q30_t y;
        logic signed [Z_WIDTH-1:0] z;
        logic [1:0] quad;
    } cordic_t;

    function automatic logic signed [Z_WIDTH-1:0] atan_q30(input int i);
        logic signed [Z_WIDTH-1:0] r;
        begin
            case (i)
                0: r = 34'sd843314857;
                1: r = 34'sd497837829;
                2: r = 34'sd263043837;
                3: r = 34'sd133525159;
                4: r = 34'sd67021687;
                5: r = 34'sd33543516;
                6: r = 34'sd16775851;
                7: r = 34'sd8388437;
                8: r = 34'sd4194283;
                9: r = 34'sd2097149;
                default: r = Z_WIDTH'(34'sd1048576 >>> (i - 10));
            endcase
            return r;
        end
    endfunction

    function automatic q30_t clamp_one(input q30_t v);
        begin
            if (v > ONE_Q30) return ONE_Q30;
            if (v < -ONE_Q30) return -ONE_Q30;
            return v;
        end
    endfunction

    // Q30 product rounded half up; inputs are within plus or minus one.
    function automatic q30_t mulq(input q30_t a, input q30_t b);
        logic signed [2*Q_WIDTH-1:0] p;
        begin
            p = a * b + (68'sd1 <<< 29);
            return Q_WIDTH'(p >>> 30);
        end
    endfunction

    function automatic out_t to_out(input q30_t v);
        localparam int SH = 32 - OUT_WIDTH;
        logic signed [Q_WIDTH:0] r;
        logic signed [Q_WIDTH:0] lim;
        begin
            lim = (Q_WIDTH+1)'(1) <<< (OUT_WIDTH - 2);
            r = (Q_WIDTH+1)'(v);
            r = (r + $signed((Q_WIDTH+1)'(1) << (SH - 1))) >>> SH;
            if (r > lim) r = lim;
            if (r < -lim) r = -lim;
            return OUT_WIDTH'(r);
        end
    endfunction

endpackage

// ===== rtl/eatbv_sincos.sv =====
// Pipelined sine and cosine of one angle: reduction, 24 CORDIC stages, fold.
// Depends on eatbv_pkg.
module eatbv_sincos (
    input  logic                                  clk,
    input  logic signed [eatbv_pkg::ANG_WIDTH-1:0] angle,
    output eatbv_pkg::q30_t                       sin_val,
    output eatbv_pkg::q30_t                       cos_val
);
    import eatbv_pkg::*;

    localparam int NST = CORDIC_STEPS;
    // PI_Q30 = 45 * PI_DIV45 + PI_MOD45, so the division by 45 splits into a
    // large exact product and a small remainder term.
    localparam logic [26:0] PI_DIV45    = 27'(PI_Q30 / 32'd45);
    localparam logic [5:0]  PI_MOD45    = 6'(PI_Q30 % 32'd45);
    localparam logic [18:0] DIV45_RECIP = 19'd372828;   // ceil(2^24/45)

    logic [12:0] f_reg;
    logic [1:0]  q_reg;
    logic [14:0] r_next;
    logic [12:0] f_next;
    logic [1:0]  q_next;
    logic [39:0] zhi_reg;
    logic [11:0] zlo_reg;
    logic [1:0]  qz_reg;
    cordic_t     st_reg [0:NST];
    cordic_t     st_next [1:NST];
    q30_t        sin_reg;
    q30_t        cos_reg;

    // Reduce to [0, 23040); inputs below minus one turn need two turns added.
    always_comb
    begin
        logic signed [16:0] a;
        a = {angle[ANG_WIDTH-1], angle};
        if (a < -17'sd23040)
            a = a + 17'sd46080;
        else if (a < 0)
            a = a + 17'sd23040;
        else if (a >= 17'sd23040)
            a = a - 17'sd23040;
        r_next = 15'(a);
        if (r_next >= 15'd17280) begin q_next = 2'd3; f_next = 13'(r_next - 15'd17280); end
        else if (r_next >= 15'd11520) begin q_next = 2'd2; f_next = 13'(r_next - 15'd11520); end
        else if (r_next >= 15'd5760) begin q_next = 2'd1; f_next = 13'(r_next - 15'd5760); end
        else begin q_next = 2'd0; f_next = 13'(r_next); end
    end

    always_comb
    begin
        for (int i = 0; i < NST; i++) begin
            q30_t xs;
            q30_t ys;
            xs = st_reg[i].x >>> i;
            ys = st_reg[i].y >>> i;
            st_next[i+1].quad = st_reg[i].quad;
            if (st_reg[i].z >= 0) begin
                st_next[i+1].x = st_reg[i].x - ys;
                st_next[i+1].y = st_reg[i].y + xs;
                st_next[i+1].z = st_reg[i].z - atan_q30(i);
            end else begin
                st_next[i+1].x = st_reg[i].x + ys;
                st_next[i+1].y = st_reg[i].y - xs;
                st_next[i+1].z = st_reg[i].z + atan_q30(i);
            end
        end
    end

    // z = (f*pi + 5760) / 11520 with 11520 = 45 * 256. The quotient by 45 is
    // f*PI_DIV45 plus (f*PI_MOD45 + 5760) / 45, the latter small enough for an
    // exact reciprocal; the shift by 8 follows in the next stage.
    logic [39:0] zhi_next;
    logic [11:0] zlo_next;
    logic [30:0] zq;
    always_comb
    begin
        logic [17:0] lo_num;
        logic [36:0] lo_prod;
        logic [39:0] zsum;
        zhi_next = 40'(f_reg) * 40'(PI_DIV45);
        lo_num = 18'(f_reg) * 18'(PI_MOD45) + 18'd5760;
        lo_prod = 37'(lo_num) * 37'(DIV45_RECIP);
        zlo_next = 12'(lo_prod >> 24);
        zsum = zhi_reg + 40'(zlo_reg);
        zq = 31'(zsum >> 8);
    end

    always_ff @(posedge clk)
    begin
        f_reg <= f_next;
        q_reg <= q_next;
        zhi_reg <= zhi_next;
        zlo_reg <= zlo_next;
        qz_reg <= q_reg;
        st_reg[0].x <= CORDIC_K;
        st_reg[0].y <= '0;
        st_reg[0].z <= Z_WIDTH'(zq);
        st_reg[0].quad <= qz_reg;
        for (int i = 1; i <= NST; i++)
            st_reg[i] <= st_next[i];
        case (st_reg[NST].quad)
            2'd0: begin sin_reg <= clamp_one(st_reg[NST].y);
                        cos_reg <= clamp_one(st_reg[NST].x); end
            2'd1: begin sin_reg <= clamp_one(st_reg[NST].x);
                        cos_reg <= -clamp_one(st_reg[NST].y); end
            2'd2: begin sin_reg <= -clamp_one(st_reg[NST].y);
                        cos_reg <= -clamp_one(st_reg[NST].x); end
            default: begin sin_reg <= -clamp_one(st_reg[NST].x);
                           cos_reg <= clamp_one(st_reg[NST].y); end
        endcase
    end

    assign sin_val = sin_reg;
    assign cos_val = cos_reg;

endmodule

// ===== rtl/euler_angles_to_basis_vectors_unit.sv =====
// Top level: Euler angles to forward, right and up unit vectors.
// Depends on eatbv_pkg and eatbv_sincos.
//
//  channel | signals                         | handshake
//  input   | pitch_deg yaw_deg roll_deg      | start high, busy low
//  result  | forward_* right_* up_*          | done strobe, one cycle
//
// One item may enter every cycle; busy is always low.
// The path runs through reduction and angle scaling, 24 CORDIC
// stages, 1 fold, then 2 product stages and 1 output stage.
// Reset clears only the valid pipe; results cannot be stalled.
module euler_angles_to_basis_vectors_unit (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  logic signed [eatbv_pkg::ANG_WIDTH-1:0] pitch_deg,
    input  logic signed [eatbv_pkg::ANG_WIDTH-1:0] yaw_deg,
    input  logic signed [eatbv_pkg::ANG_WIDTH-1:0] roll_deg,
    output logic                                   done,
    output eatbv_pkg::out_t                        forward_x,
    output eatbv_pkg::out_t                        forward_y,
    output eatbv_pkg::out_t                        forward_z,
    output eatbv_pkg::out_t                        right_x,
    output eatbv_pkg::out_t                        right_y,
    output eatbv_pkg::out_t                        right_z,
    output eatbv_pkg::out_t                        up_x,
    output eatbv_pkg::out_t                        up_y,
    output eatbv_pkg::out_t                        up_z
);
    import eatbv_pkg::*;

    localparam int LAT = 3 + CORDIC_STEPS + 1 + 3;

    q30_t sp, cp, sy, cy, sr, cr;

    eatbv_sincos u_p (.clk(clk), .angle(pitch_deg), .sin_val(sp), .cos_val(cp));
    eatbv_sincos u_y (.clk(clk), .angle(yaw_deg), .sin_val(sy), .cos_val(cy));
    eatbv_sincos u_r (.clk(clk), .angle(roll_deg), .sin_val(sr), .cos_val(cr));

    logic [LAT-1:0] vld_reg;
    logic [LAT-1:0] vld_next;

    // Product stage one.
    q30_t srsp_reg, crsp_reg, cpcy_reg, cpsy_reg, nsp_reg, srcp_reg, crcp_reg;
    q30_t crsy_reg, crcy_reg, srsy_reg, srcy_reg, cy1_reg, sy1_reg;
    // Product stage two.
    q30_t a0_reg, a1_reg, a2_reg, b3_reg, b4_reg, a5_reg, b6_reg, b7_reg, a8_reg;
    q30_t c3_reg, c4_reg, c6_reg, c7_reg;
    out_t o_reg [0:8];

    always_ff @(posedge clk)
    begin
        srsp_reg <= mulq(sr, sp);
        crsp_reg <= mulq(cr, sp);
        cpcy_reg <= mulq(cp, cy);
        cpsy_reg <= mulq(cp, sy);
        nsp_reg  <= -sp;
        srcp_reg <= mulq(sr, cp);
        crcp_reg <= mulq(cr, cp);
        crsy_reg <= mulq(cr, sy);
        crcy_reg <= mulq(cr, cy);
        srsy_reg <= mulq(sr, sy);
        srcy_reg <= mulq(sr, cy);
        cy1_reg  <= cy;
        sy1_reg  <= sy;

        a0_reg <= cpcy_reg;
        a1_reg <= cpsy_reg;
        a2_reg <= nsp_reg;
        b3_reg <= -mulq(srsp_reg, cy1_reg);
        c3_reg <= crsy_reg;
        b4_reg <= -mulq(srsp_reg, sy1_reg);
        c4_reg <= -crcy_reg;
        a5_reg <= -srcp_reg;
        b6_reg <= mulq(crsp_reg, cy1_reg);
        c6_reg <= srsy_reg;
        b7_reg <= mulq(crsp_reg, sy1_reg);
        c7_reg <= -srcy_reg;
        a8_reg <= crcp_reg;

        o_reg[0] <= to_out(a0_reg);
        o_reg[1] <= to_out(a1_reg);
        o_reg[2] <= to_out(a2_reg);
        o_reg[3] <= to_out(b3_reg + c3_reg);
        o_reg[4] <= to_out(b4_reg + c4_reg);
        o_reg[5] <= to_out(a5_reg);
        o_reg[6] <= to_out(b6_reg + c6_reg);
        o_reg[7] <= to_out(b7_reg + c7_reg);
        o_reg[8] <= to_out(a8_reg);
    end

    assign vld_next = {vld_reg[LAT-2:0], start};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= vld_next;
    end

    assign busy      = 1'b0;
    assign done      = vld_reg[LAT-1];
    assign forward_x = o_reg[0];
    assign forward_y = o_reg[1];
    assign forward_z = o_reg[2];
    assign right_x   = o_reg[3];
    assign right_y   = o_reg[4];
    assign right_z   = o_reg[5];
    assign up_x      = o_reg[6];
    assign up_y      = o_reg[7];
    assign up_z      = o_reg[8];

`ifndef SYNTHESIS
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        done == $past(vld_reg[LAT-2])) else $error("done lost its item");
    a_fz_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (forward_z <= 16'sd16384 && forward_z >= -16'sd16384))
        else $error("forward_z out of range");
    a_upz_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (up_z <= 16'sd16384 && up_z >= -16'sd16384))
        else $error("up_z out of range");
`endif

endmodule
